@@ rtl/tls_client_hello_field_extractor_assert.svh @@
// Assertion macros for the ClientHello field extractor.
`ifndef TLS_CLIENT_HELLO_FIELD_EXTRACTOR_ASSERT_SVH
`define TLS_CLIENT_HELLO_FIELD_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define TLSCHE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlsche: same-cycle check failed");
// Next-cycle implication under reset.
`define TLSCHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlsche: next-cycle check failed");
`else
`define TLSCHE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TLSCHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/tlsche_pkg.sv @@
package tlsche_pkg;

    // Input transaction: one payload byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } t_in;

    // Output transaction: one extracted field or the summary.
    typedef struct packed {
        logic [2:0]  kind_of_result;
        logic [15:0] field_value;
        logic [1:0]  status_code;
        logic [2:0]  version_code;
        logic [1:0]  alpn_code;
        logic        sni_present;
        logic        run_last;
    } t_out;

    // Up to two results produced by one byte.
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_res_pair;

    // Parser phases.
    localparam logic [4:0] P_CTYPE   = 5'd0;
    localparam logic [4:0] P_MAJOR   = 5'd1;
    localparam logic [4:0] P_MINOR   = 5'd2;
    localparam logic [4:0] P_RLEN    = 5'd3;
    localparam logic [4:0] P_HTYPE   = 5'd4;
    localparam logic [4:0] P_HLEN    = 5'd5;
    localparam logic [4:0] P_VER     = 5'd6;
    localparam logic [4:0] P_RAND    = 5'd7;
    localparam logic [4:0] P_SIDL    = 5'd8;
    localparam logic [4:0] P_SID     = 5'd9;
    localparam logic [4:0] P_CSL     = 5'd10;
    localparam logic [4:0] P_CS      = 5'd11;
    localparam logic [4:0] P_CML     = 5'd12;
    localparam logic [4:0] P_CM      = 5'd13;
    localparam logic [4:0] P_EXTL    = 5'd14;
    localparam logic [4:0] P_EHDR    = 5'd15;
    localparam logic [4:0] P_ESKIP   = 5'd16;
    localparam logic [4:0] P_SNI_LL  = 5'd17;
    localparam logic [4:0] P_SNI_T   = 5'd18;
    localparam logic [4:0] P_SNI_NL  = 5'd19;
    localparam logic [4:0] P_SNI_N   = 5'd20;
    localparam logic [4:0] P_SIG_LL  = 5'd21;
    localparam logic [4:0] P_SIG_P   = 5'd22;
    localparam logic [4:0] P_ALPN_LL = 5'd23;
    localparam logic [4:0] P_ALPN_PL = 5'd24;
    localparam logic [4:0] P_ALPN_P  = 5'd25;
    localparam logic [4:0] P_SV_L    = 5'd26;
    localparam logic [4:0] P_SV_P    = 5'd27;
    localparam logic [4:0] P_RSKIP   = 5'd28;
    localparam logic [4:0] P_DONE    = 5'd29;

    // Result kinds.
    localparam logic [2:0] K_CIPHER = 3'd0;
    localparam logic [2:0] K_EXT    = 3'd1;
    localparam logic [2:0] K_SIG    = 3'd2;
    localparam logic [2:0] K_SNI    = 3'd3;
    localparam logic [2:0] K_SUM    = 3'd4;

    // Summary status codes.
    localparam logic [1:0] S_OK        = 2'd0;
    localparam logic [1:0] S_NOT_HELLO = 2'd1;
    localparam logic [1:0] S_TRUNC     = 2'd2;
    localparam logic [1:0] S_MALFORMED = 2'd3;

    // Version and ALPN codes.
    localparam logic [2:0] V_UNKNOWN = 3'd0;
    localparam logic [2:0] V_TLS10   = 3'd1;
    localparam logic [2:0] V_TLS11   = 3'd2;
    localparam logic [2:0] V_TLS12   = 3'd3;
    localparam logic [2:0] V_TLS13   = 3'd4;
    localparam logic [1:0] A_NONE    = 2'd0;
    localparam logic [1:0] A_H2      = 2'd1;
    localparam logic [1:0] A_HTTP11  = 2'd2;

    // Protocol constants.
    localparam logic [7:0]  CT_HANDSHAKE  = 8'd22;
    localparam logic [7:0]  MAJOR_TLS     = 8'h03;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
    localparam logic [23:0] MIN_HELLO_LEN = 24'd42;
    localparam logic [15:0] EXT_SNI       = 16'h0000;
    localparam logic [15:0] EXT_SIG       = 16'h000d;
    localparam logic [15:0] EXT_ALPN      = 16'h0010;
    localparam logic [15:0] EXT_SV        = 16'h002b;
    localparam logic [15:0] ALPN_H2       = 16'h6832;
    localparam logic [63:0] ALPN_HTTP11   = 64'h687474702F312E31;

    // Map a wire version to its code.
    function automatic logic [2:0] f_ver_code(input logic [15:0] v);
        logic [2:0] c;
        unique case (v)
            16'h0304: c = V_TLS13;
            16'h0303: c = V_TLS12;
            16'h0302: c = V_TLS11;
            16'h0301: c = V_TLS10;
            default:  c = V_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/tlsche_parser.sv @@
module tlsche_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  tlsche_pkg::t_in       i_data,
    output tlsche_pkg::t_res_pair o_res
);

    logic [4:0]  r_phase, n_phase;
    logic [15:0] r_rcount, n_rcount;
    logic [15:0] r_rlen, n_rlen;
    logic [23:0] r_blen, n_blen;
    logic [15:0] r_sec, n_sec;
    logic [15:0] r_extr, n_extr;
    logic [15:0] r_list, n_list;
    logic [23:0] r_hold, n_hold;
    logic [63:0] r_abuf, n_abuf;
    logic [2:0]  r_ver, n_ver;
    logic [1:0]  r_alpn, n_alpn;
    logic        r_sni, n_sni;
    logic        r_bfail, n_bfail;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_plen, n_plen;
    logic        r_shost, n_shost;
    logic        r_semit, n_semit;

    // Append a result, dropping any beyond two.
    function automatic void f_put(inout logic [1:0] cnt, inout tlsche_pkg::t_out r0,
                                  inout tlsche_pkg::t_out r1, input tlsche_pkg::t_out x);
        if (cnt == 2'd0) begin
            r0 = x;
        end else if (cnt == 2'd1) begin
            r1 = x;
        end
        if (cnt != 2'd2) begin
            cnt = cnt + 2'd1;
        end
    endfunction

    function automatic tlsche_pkg::t_out f_field(input logic [2:0] k, input logic [15:0] v);
        tlsche_pkg::t_out o;
        o = '0;
        o.kind_of_result = k;
        o.field_value = v;
        return o;
    endfunction

    function automatic tlsche_pkg::t_out f_sum(input logic [1:0] st, input logic [2:0] ver,
                                               input logic [1:0] al, input logic sn);
        tlsche_pkg::t_out o;
        o = '0;
        o.kind_of_result = tlsche_pkg::K_SUM;
        o.status_code = st;
        if (st == tlsche_pkg::S_OK) begin
            o.version_code = ver;
            o.alpn_code = al;
            o.sni_present = sn;
        end
        return o;
    endfunction

    // Next-state and result logic for one byte.
    always_comb begin
        logic [7:0]  b;
        logic [4:0]  prev;
        logic [15:0] r;
        logic [15:0] h16;
        logic [1:0]  cnt;
        tlsche_pkg::t_out res0;
        tlsche_pkg::t_out res1;
        b = i_data.data_byte;
        prev = r_phase;
        cnt = 2'd0;
        res0 = '0;
        res1 = '0;
        r = '0;
        h16 = '0;
        n_phase = r_phase; n_rcount = r_rcount; n_rlen = r_rlen; n_blen = r_blen;
        n_sec = r_sec; n_extr = r_extr; n_list = r_list; n_hold = r_hold;
        n_abuf = r_abuf; n_ver = r_ver; n_alpn = r_alpn; n_sni = r_sni;
        n_bfail = r_bfail; n_hcnt = r_hcnt; n_etype = r_etype; n_plen = r_plen;
        n_shost = r_shost; n_semit = r_semit;

        if (prev <= tlsche_pkg::P_RLEN) begin
            // Record header bytes.
            unique case (prev)
                tlsche_pkg::P_CTYPE: begin
                    if (b != tlsche_pkg::CT_HANDSHAKE) begin
                        f_put(cnt, res0, res1, f_sum(tlsche_pkg::S_NOT_HELLO, n_ver, n_alpn, n_sni));
                        n_phase = tlsche_pkg::P_DONE;
                    end else begin
                        n_phase = tlsche_pkg::P_MAJOR;
                    end
                end
                tlsche_pkg::P_MAJOR: begin
                    if (b != tlsche_pkg::MAJOR_TLS) begin
                        f_put(cnt, res0, res1, f_sum(tlsche_pkg::S_NOT_HELLO, n_ver, n_alpn, n_sni));
                        n_phase = tlsche_pkg::P_DONE;
                    end else begin
                        n_phase = tlsche_pkg::P_MINOR;
                    end
                end
                tlsche_pkg::P_MINOR: begin
                    if (b < 8'd1 || b > 8'd4) begin
                        f_put(cnt, res0, res1, f_sum(tlsche_pkg::S_NOT_HELLO, n_ver, n_alpn, n_sni));
                        n_phase = tlsche_pkg::P_DONE;
                    end else begin
                        n_phase = tlsche_pkg::P_RLEN;
                        n_hcnt = '0;
                        n_hold = '0;
                    end
                end
                default: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        n_rlen = n_hold[15:0];
                        n_rcount = '0;
                        n_hcnt = '0;
                        n_hold = '0;
                        if (n_rlen < 16'd4) begin
                            n_bfail = 1'b1;
                            n_phase = tlsche_pkg::P_RSKIP;
                            if (n_rlen == 16'd0) begin
                                f_put(cnt, res0, res1,
                                      f_sum(tlsche_pkg::S_MALFORMED, n_ver, n_alpn, n_sni));
                                n_phase = tlsche_pkg::P_DONE;
                            end
                        end else begin
                            n_phase = tlsche_pkg::P_HTYPE;
                        end
                    end
                end
            endcase
        end else if (prev < tlsche_pkg::P_DONE) begin
            n_rcount = n_rcount + 16'd1;

            // Running length counters of the enclosing sections.
            if (prev >= tlsche_pkg::P_VER && prev <= tlsche_pkg::P_SV_P && n_blen != '0) begin
                n_blen = n_blen - 24'd1;
            end
            if (prev >= tlsche_pkg::P_EHDR && prev <= tlsche_pkg::P_SV_P && n_extr != '0) begin
                n_extr = n_extr - 16'd1;
            end
            if (prev >= tlsche_pkg::P_ESKIP && prev <= tlsche_pkg::P_SV_P && n_sec != '0) begin
                n_sec = n_sec - 16'd1;
            end
            r = n_sec;

            // Body field walk.
            case (prev)
                tlsche_pkg::P_HTYPE: begin
                    if (b != tlsche_pkg::HS_CLIENT_HELLO) begin
                        f_put(cnt, res0, res1, f_sum(tlsche_pkg::S_NOT_HELLO, n_ver, n_alpn, n_sni));
                        n_phase = tlsche_pkg::P_DONE;
                    end else begin
                        n_phase = tlsche_pkg::P_HLEN;
                        n_hcnt = '0;
                        n_hold = '0;
                    end
                end
                tlsche_pkg::P_HLEN: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd3) begin
                        if (({1'b0, n_hold} + 25'd4) > {9'd0, n_rlen} ||
                            n_hold < tlsche_pkg::MIN_HELLO_LEN) begin
                            n_bfail = 1'b1;
                            n_phase = tlsche_pkg::P_RSKIP;
                        end else begin
                            n_blen = n_hold;
                            n_phase = tlsche_pkg::P_VER;
                        end
                        n_hcnt = '0;
                        n_hold = '0;
                    end
                end
                tlsche_pkg::P_VER: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        n_ver = tlsche_pkg::f_ver_code(n_hold[15:0]);
                        n_sec = 16'd32;
                        n_phase = tlsche_pkg::P_RAND;
                    end
                end
                tlsche_pkg::P_RAND: begin
                    if (n_sec != '0) n_sec = n_sec - 16'd1;
                    if (n_sec == '0) n_phase = tlsche_pkg::P_SIDL;
                end
                tlsche_pkg::P_SIDL: begin
                    if ({16'd0, b} > n_blen) begin
                        n_bfail = 1'b1;
                        n_phase = tlsche_pkg::P_RSKIP;
                    end else begin
                        n_sec = {8'd0, b};
                        n_hcnt = '0;
                        n_hold = '0;
                        n_phase = (b == 8'd0) ? tlsche_pkg::P_CSL : tlsche_pkg::P_SID;
                    end
                end
                tlsche_pkg::P_SID: begin
                    if (n_sec != '0) n_sec = n_sec - 16'd1;
                    if (n_sec == '0) begin
                        n_phase = tlsche_pkg::P_CSL;
                        n_hcnt = '0;
                        n_hold = '0;
                    end
                end
                tlsche_pkg::P_CSL: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        h16 = n_hold[15:0];
                        if ({8'd0, h16} > n_blen || h16[0]) begin
                            n_bfail = 1'b1;
                            n_phase = tlsche_pkg::P_RSKIP;
                        end else begin
                            n_sec = h16;
                            n_hcnt = '0;
                            n_hold = '0;
                            n_phase = (h16 == '0) ? tlsche_pkg::P_CML : tlsche_pkg::P_CS;
                        end
                    end
                end
                tlsche_pkg::P_CS: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_sec != '0) n_sec = n_sec - 16'd1;
                    if (n_hcnt == 3'd2) begin
                        f_put(cnt, res0, res1, f_field(tlsche_pkg::K_CIPHER, n_hold[15:0]));
                        n_hcnt = '0;
                        n_hold = '0;
                    end
                    if (n_sec == '0) n_phase = tlsche_pkg::P_CML;
                end
                tlsche_pkg::P_CML: begin
                    if ({16'd0, b} > n_blen) begin
                        n_bfail = 1'b1;
                        n_phase = tlsche_pkg::P_RSKIP;
                    end else begin
                        n_sec = {8'd0, b};
                        n_hcnt = '0;
                        n_hold = '0;
                        n_phase = (b == 8'd0) ? tlsche_pkg::P_EXTL : tlsche_pkg::P_CM;
                    end
                end
                tlsche_pkg::P_CM: begin
                    if (n_sec != '0) n_sec = n_sec - 16'd1;
                    if (n_sec == '0) begin
                        n_phase = tlsche_pkg::P_EXTL;
                        n_hcnt = '0;
                        n_hold = '0;
                    end
                end
                tlsche_pkg::P_EXTL: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        h16 = n_hold[15:0];
                        if ({8'd0, h16} > n_blen) begin
                            n_bfail = 1'b1;
                            n_phase = tlsche_pkg::P_RSKIP;
                        end else begin
                            n_extr = h16;
                            if (n_extr >= 16'd4) begin
                                n_phase = tlsche_pkg::P_EHDR;
                                n_hcnt = '0;
                                n_hold = '0;
                            end else begin
                                n_phase = tlsche_pkg::P_RSKIP;
                            end
                        end
                    end
                end
                tlsche_pkg::P_EHDR: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        n_etype = n_hold[15:0];
                        f_put(cnt, res0, res1, f_field(tlsche_pkg::K_EXT, n_etype));
                        n_hold = '0;
                    end else if (n_hcnt == 3'd4) begin
                        // Extension body length: choose how to walk it.
                        h16 = n_hold[15:0];
                        if (h16 > n_extr) begin
                            n_bfail = 1'b1;
                            n_phase = tlsche_pkg::P_RSKIP;
                        end else begin
                            n_sec = h16;
                            n_hcnt = '0;
                            n_hold = '0;
                            n_phase = tlsche_pkg::P_ESKIP;
                            if (n_etype == tlsche_pkg::EXT_SNI && h16 >= 16'd2) begin
                                n_phase = tlsche_pkg::P_SNI_LL;
                            end else if (n_etype == tlsche_pkg::EXT_SIG && h16 >= 16'd2) begin
                                n_phase = tlsche_pkg::P_SIG_LL;
                            end else if (n_etype == tlsche_pkg::EXT_ALPN && h16 >= 16'd2) begin
                                n_phase = tlsche_pkg::P_ALPN_LL;
                            end else if (n_etype == tlsche_pkg::EXT_SV && h16 >= 16'd3) begin
                                n_phase = tlsche_pkg::P_SV_L;
                            end
                            if (h16 == '0) begin
                                if (n_extr >= 16'd4) begin
                                    n_phase = tlsche_pkg::P_EHDR;
                                    n_hcnt = '0;
                                    n_hold = '0;
                                end else begin
                                    n_phase = tlsche_pkg::P_RSKIP;
                                end
                            end
                        end
                    end
                end
                tlsche_pkg::P_SNI_LL: begin
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        n_phase = (r >= 16'd3) ? tlsche_pkg::P_SNI_T : tlsche_pkg::P_ESKIP;
                    end
                end
                tlsche_pkg::P_SNI_T: begin
                    n_shost = (b == 8'd0);
                    n_hcnt = '0;
                    n_hold = '0;
                    n_phase = tlsche_pkg::P_SNI_NL;
                end
                tlsche_pkg::P_SNI_NL: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        h16 = n_hold[15:0];
                        if (h16 > r) begin
                            n_bfail = 1'b1;
                            n_phase = tlsche_pkg::P_RSKIP;
                        end else begin
                            n_semit = n_shost && !n_sni;
                            if (n_shost) n_sni = 1'b1;
                            n_list = h16;
                            if (h16 == '0) begin
                                n_phase = (n_shost || n_sec < 16'd3) ?
                                          tlsche_pkg::P_ESKIP : tlsche_pkg::P_SNI_T;
                            end else begin
                                n_phase = tlsche_pkg::P_SNI_N;
                            end
                        end
                    end
                end
                tlsche_pkg::P_SNI_N: begin
                    if (n_semit) f_put(cnt, res0, res1, f_field(tlsche_pkg::K_SNI, {8'd0, b}));
                    if (n_list != '0) n_list = n_list - 16'd1;
                    if (n_list == '0) begin
                        n_phase = (n_shost || n_sec < 16'd3) ?
                                  tlsche_pkg::P_ESKIP : tlsche_pkg::P_SNI_T;
                    end
                end
                tlsche_pkg::P_SIG_LL: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        h16 = n_hold[15:0];
                        n_list = (h16 <= r) ? h16 : 16'd0;
                        n_hcnt = '0;
                        n_hold = '0;
                        n_phase = (n_list >= 16'd2) ? tlsche_pkg::P_SIG_P : tlsche_pkg::P_ESKIP;
                    end
                end
                tlsche_pkg::P_SIG_P: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_list != '0) n_list = n_list - 16'd1;
                    if (n_hcnt == 3'd2) begin
                        f_put(cnt, res0, res1, f_field(tlsche_pkg::K_SIG, n_hold[15:0]));
                        n_hcnt = '0;
                        n_hold = '0;
                        if (n_list < 16'd2) n_phase = tlsche_pkg::P_ESKIP;
                    end
                end
                tlsche_pkg::P_ALPN_LL: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_hcnt == 3'd2) begin
                        h16 = n_hold[15:0];
                        if (h16 <= r && h16 >= 16'd1) begin
                            n_list = h16;
                            n_phase = tlsche_pkg::P_ALPN_PL;
                        end else begin
                            n_phase = tlsche_pkg::P_ESKIP;
                        end
                    end
                end
                tlsche_pkg::P_ALPN_PL: begin
                    if (n_list != '0) n_list = n_list - 16'd1;
                    n_plen = b;
                    if ({8'd0, b} > r) begin
                        n_phase = tlsche_pkg::P_ESKIP;
                    end else begin
                        n_hold = {16'd0, b};
                        n_abuf = '0;
                        if (b == 8'd0) begin
                            // An empty protocol name cannot match.
                            n_phase = (n_list != '0 && n_sec != '0) ?
                                      tlsche_pkg::P_ALPN_PL : tlsche_pkg::P_ESKIP;
                        end else begin
                            n_phase = tlsche_pkg::P_ALPN_P;
                        end
                    end
                end
                tlsche_pkg::P_ALPN_P: begin
                    n_abuf = {n_abuf[55:0], b};
                    if (n_list != '0) n_list = n_list - 16'd1;
                    if (n_hold != '0) n_hold = n_hold - 24'd1;
                    if (n_hold == '0) begin
                        // Name complete: first match wins.
                        if (n_alpn == tlsche_pkg::A_NONE) begin
                            if (n_plen == 8'd2 && n_abuf[15:0] == tlsche_pkg::ALPN_H2) begin
                                n_alpn = tlsche_pkg::A_H2;
                            end else if (n_plen == 8'd8 && n_abuf == tlsche_pkg::ALPN_HTTP11) begin
                                n_alpn = tlsche_pkg::A_HTTP11;
                            end
                        end
                        n_phase = (n_list != '0 && n_sec != '0) ?
                                  tlsche_pkg::P_ALPN_PL : tlsche_pkg::P_ESKIP;
                    end
                end
                tlsche_pkg::P_SV_L: begin
                    if ({8'd0, b} <= r && b >= 8'd2) begin
                        n_list = {8'd0, b};
                        n_hcnt = '0;
                        n_hold = '0;
                        n_phase = tlsche_pkg::P_SV_P;
                    end else begin
                        n_phase = tlsche_pkg::P_ESKIP;
                    end
                end
                tlsche_pkg::P_SV_P: begin
                    n_hold = {n_hold[15:0], b};
                    n_hcnt = n_hcnt + 3'd1;
                    if (n_list != '0) n_list = n_list - 16'd1;
                    if (n_hcnt == 3'd2) begin
                        h16 = n_hold[15:0];
                        n_hcnt = '0;
                        n_hold = '0;
                        if (tlsche_pkg::f_ver_code(h16) != tlsche_pkg::V_UNKNOWN) begin
                            n_ver = tlsche_pkg::f_ver_code(h16);
                        end
                        if (tlsche_pkg::f_ver_code(h16) == tlsche_pkg::V_TLS13 ||
                            n_list < 16'd2) begin
                            n_phase = tlsche_pkg::P_ESKIP;
                        end
                    end
                end
                default: begin
                end
            endcase

            // End of the current extension.
            if (prev >= tlsche_pkg::P_ESKIP && prev <= tlsche_pkg::P_SV_P &&
                n_phase >= tlsche_pkg::P_ESKIP && n_phase <= tlsche_pkg::P_SV_P &&
                n_sec == '0) begin
                if (n_extr >= 16'd4) begin
                    n_phase = tlsche_pkg::P_EHDR;
                    n_hcnt = '0;
                    n_hold = '0;
                end else begin
                    n_phase = tlsche_pkg::P_RSKIP;
                end
            end

            // End of the ClientHello body.
            if (prev >= tlsche_pkg::P_VER && prev <= tlsche_pkg::P_SV_P && n_blen == '0) begin
                if (n_phase >= tlsche_pkg::P_VER && n_phase <= tlsche_pkg::P_CM) begin
                    n_bfail = 1'b1;
                    n_phase = tlsche_pkg::P_RSKIP;
                end else if (n_phase >= tlsche_pkg::P_EXTL && n_phase <= tlsche_pkg::P_SV_P) begin
                    n_phase = tlsche_pkg::P_RSKIP;
                end
            end

            // End of the record.
            if (n_phase != tlsche_pkg::P_DONE && n_rcount >= n_rlen) begin
                f_put(cnt, res0, res1,
                      f_sum((n_bfail || n_phase != tlsche_pkg::P_RSKIP) ?
                            tlsche_pkg::S_MALFORMED : tlsche_pkg::S_OK,
                            n_ver, n_alpn, n_sni));
                n_phase = tlsche_pkg::P_DONE;
            end
        end

        // End of the payload: early end is a truncation, then start over.
        if (i_data.end_of_payload) begin
            if (n_phase != tlsche_pkg::P_DONE) begin
                f_put(cnt, res0, res1, f_sum(tlsche_pkg::S_TRUNC, n_ver, n_alpn, n_sni));
            end
            n_phase = tlsche_pkg::P_CTYPE; n_rcount = '0; n_rlen = '0; n_blen = '0;
            n_sec = '0; n_extr = '0; n_list = '0; n_hold = '0; n_abuf = '0;
            n_ver = '0; n_alpn = '0; n_sni = 1'b0; n_bfail = 1'b0; n_hcnt = '0;
            n_etype = '0; n_plen = '0; n_shost = 1'b0; n_semit = 1'b0;
        end

        // Flag the last result of this byte.
        if (cnt == 2'd1) res0.run_last = 1'b1;
        if (cnt == 2'd2) res1.run_last = 1'b1;

        o_res.count = i_step ? cnt : 2'd0;
        o_res.res0 = res0;
        o_res.res1 = res1;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tlsche_pkg::P_CTYPE; r_rcount <= '0; r_rlen <= '0; r_blen <= '0;
            r_sec <= '0; r_extr <= '0; r_list <= '0; r_hold <= '0; r_abuf <= '0;
            r_ver <= '0; r_alpn <= '0; r_sni <= 1'b0; r_bfail <= 1'b0; r_hcnt <= '0;
            r_etype <= '0; r_plen <= '0; r_shost <= 1'b0; r_semit <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_rcount <= n_rcount; r_rlen <= n_rlen; r_blen <= n_blen;
            r_sec <= n_sec; r_extr <= n_extr; r_list <= n_list; r_hold <= n_hold;
            r_abuf <= n_abuf; r_ver <= n_ver; r_alpn <= n_alpn; r_sni <= n_sni;
            r_bfail <= n_bfail; r_hcnt <= n_hcnt; r_etype <= n_etype; r_plen <= n_plen;
            r_shost <= n_shost; r_semit <= n_semit;
        end
    end

endmodule

@@ rtl/tlsche_out_queue.sv @@
module tlsche_out_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlsche_pkg::t_res_pair i_push,
    output logic                  o_room,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output tlsche_pkg::t_out      o_out_data
);

    tlsche_pkg::t_out r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       w_pop;

    assign w_pop = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data = r_mem[r_rd];
    // Room for the two results a byte can produce.
    assign o_room = (r_cnt <= 3'd2);

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push.count} - {2'd0, w_pop};
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= r_wr + i_push.count;
            r_rd <= r_rd + {1'b0, w_pop};
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/tls_client_hello_field_extractor.sv @@
// ClientHello field extractor: takes one TCP payload byte per transaction, starting at the
// TLS record header, and returns cipher suites, extension types, signature algorithms, SNI
// host name bytes and one summary per record or payload. A byte is taken every cycle while
// the queue has room; each byte yields at most two results, and the output side drains one
// result per cycle from a four-entry queue while i_out_ready is high, so bytes with
// two results slow the input down to the output rate.
`include "tls_client_hello_field_extractor_assert.svh"
module tls_client_hello_field_extractor (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tlsche_pkg::t_in  i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tlsche_pkg::t_out o_out_data
);

    logic                  r_in_valid;
    tlsche_pkg::t_in       r_in;
    logic                  w_room;
    logic                  w_step;
    tlsche_pkg::t_res_pair w_res;

    // A held byte is parsed once the queue can take its results.
    assign w_step = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_step;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    tlsche_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_data  (r_in),
        .o_res   (w_res)
    );

    tlsche_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A byte that cannot be parsed stays in the input register.
    `TLSCHE_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, r_in_valid && !w_step, r_in_valid && $stable(r_in))
    // An empty input register always takes a transaction.
    `TLSCHE_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !r_in_valid, o_in_ready)
    // Results are only produced by a parsed byte.
    `TLSCHE_ASSERT_IMPL(a_push_on_step, i_clk, i_rst_n, w_res.count != 2'd0, w_step)

endmodule
